/* sv/stt_pkg.sv */
// ============================================================================
// stt_pkg
// shared types, codes and constants of the slot timer table
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    localparam int TIMER_SLOTS_DEF = 8;
    localparam int MAX_FIRES       = 8;
    localparam int FIRE_W          = $clog2(MAX_FIRES + 1);

    localparam int S_DATA_W = 96;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_SET    = 2'd0,
        MODE_UNSET  = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_CANCEL = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRE   = 1'b1;

    typedef struct packed {
        logic [31:0] period;
        logic        periodic;
        logic [31:0] expiry;
        logic [15:0] event_id;
        logic [7:0]  owner_id;
    } t_slot;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    adv;
        logic    wr_set;
        logic    clr_one;
        logic    clr_all;
        logic    fire;
        logic    push_pend;
        logic    emit;
        t_status status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  slot_free;
        logic  match;
        logic  expired;
        logic  last_slot;
        logic  fires_full_next;
        logic  pend;
        logic  out_free;
    } t_stat;

endpackage

`default_nettype wire

/* sv/stt_ctrl.sv */
// ============================================================================
// stt_ctrl
// command sequencer: walks the slots and steers the datapath
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire stt_pkg::t_stat i_stat,
    output stt_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    stt_pkg::t_status r_status, n_status;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_status   = stt_pkg::ST_OK;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                case (i_stat.mode)
                    stt_pkg::MODE_CANCEL: begin
                        o_cmd.clr_all = 1'b1;
                        n_status      = stt_pkg::ST_OK;
                        n_state       = S_DONE;
                    end
                    stt_pkg::MODE_SET: begin
                        if (i_stat.slot_free) begin
                            o_cmd.wr_set = 1'b1;
                            n_status     = stt_pkg::ST_OK;
                            n_state      = S_DONE;
                        end else if (i_stat.last_slot) begin
                            n_status = stt_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.adv = 1'b1;
                        end
                    end
                    stt_pkg::MODE_UNSET: begin
                        if (i_stat.match) begin
                            o_cmd.clr_one = 1'b1;
                            n_status      = stt_pkg::ST_OK;
                            n_state       = S_DONE;
                        end else if (i_stat.last_slot) begin
                            n_status = stt_pkg::ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.adv = 1'b1;
                        end
                    end
                    stt_pkg::MODE_TICK: begin
                        if (i_stat.expired) begin
                            if (!i_stat.pend || i_stat.out_free) begin
                                o_cmd.fire      = 1'b1;
                                o_cmd.push_pend = i_stat.pend;
                                if (i_stat.fires_full_next || i_stat.last_slot) begin
                                    n_state = S_DONE;
                                end else begin
                                    o_cmd.adv = 1'b1;
                                end
                            end
                        end else if (i_stat.last_slot) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.adv = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= stt_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire

/* sv/stt_dp.sv */
// ============================================================================
// stt_dp
// slot storage, command latch, pending fire and output register
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stt_dp #(
    parameter int TIMER_SLOTS = stt_pkg::TIMER_SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [stt_pkg::S_DATA_W-1:0]  i_s_tdata,
    input  wire logic [stt_pkg::S_USER_W-1:0]  i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [stt_pkg::M_DATA_W-1:0]       o_m_tdata,
    output logic                               o_m_tuser,
    output logic                               o_m_tlast,
    input  wire stt_pkg::t_cmd                 i_cmd,
    output stt_pkg::t_stat                     o_stat
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    // latched command
    stt_pkg::t_mode r_mode;
    logic [31:0]    r_now;
    logic [7:0]     r_owner;
    logic [15:0]    r_event;
    logic [31:0]    r_dur;
    logic           r_per;

    logic [TIMER_SLOTS-1:0]  r_valid;
    stt_pkg::t_slot          r_mem [TIMER_SLOTS];
    stt_pkg::t_slot          r_rd;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        rd_addr;
    logic [stt_pkg::FIRE_W-1:0] r_nfire;

    logic        r_pend_v;
    logic [7:0]  r_pend_owner;
    logic [15:0] r_pend_event;

    logic             r_out_valid;
    logic             r_out_kind;
    stt_pkg::t_status r_out_status;
    logic [7:0]       r_out_owner;
    logic [15:0]      r_out_event;
    logic             r_out_last;

    logic        cur_valid;
    logic        out_free;
    logic [31:0] age;

    assign cur_valid = r_valid[r_idx];
    assign out_free  = !r_out_valid || i_m_tready;
    assign age       = r_now - r_rd.expiry;

    assign o_stat.mode            = r_mode;
    assign o_stat.slot_free       = !cur_valid;
    assign o_stat.match           = cur_valid && (r_rd.owner_id == r_owner)
                                    && (r_rd.event_id == r_event);
    assign o_stat.expired         = cur_valid && !age[31];
    assign o_stat.last_slot       = (r_idx == IDX_W'(TIMER_SLOTS - 1));
    assign o_stat.fires_full_next = (r_nfire == stt_pkg::FIRE_W'(stt_pkg::MAX_FIRES - 1));
    assign o_stat.pend            = r_pend_v;
    assign o_stat.out_free        = out_free;

    // read runs one slot ahead so data is ready when the index moves
    always_comb begin
        if (i_cmd.load) begin
            rd_addr = '0;
        end else if (i_cmd.adv) begin
            rd_addr = r_idx + IDX_W'(1);
        end else begin
            rd_addr = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= stt_pkg::t_mode'(i_s_tuser);
            r_now   <= i_s_tdata[31:0];
            r_owner <= i_s_tdata[39:32];
            r_event <= i_s_tdata[55:40];
            r_dur   <= i_s_tdata[87:56];
            r_per   <= i_s_tdata[88];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_set) begin
            r_mem[r_idx] <= '{period: r_dur, periodic: r_per, expiry: r_now + r_dur,
                              event_id: r_event, owner_id: r_owner};
        end else if (i_cmd.fire && r_rd.periodic) begin
            r_mem[r_idx] <= '{period: r_rd.period, periodic: r_rd.periodic,
                              expiry: r_now + r_rd.period,
                              event_id: r_rd.event_id, owner_id: r_rd.owner_id};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clr_all) begin
            r_valid <= '0;
        end else if (i_cmd.wr_set) begin
            r_valid[r_idx] <= 1'b1;
        end else if (i_cmd.clr_one || (i_cmd.fire && !r_rd.periodic)) begin
            r_valid[r_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_nfire  <= '0;
            r_pend_v <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx    <= '0;
            r_nfire  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_cmd.adv) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.fire) begin
                r_nfire  <= r_nfire + stt_pkg::FIRE_W'(1);
                r_pend_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fire) begin
            r_pend_owner <= r_rd.owner_id;
            r_pend_event <= r_rd.event_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_pend || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_pend) begin
            r_out_kind   <= stt_pkg::KIND_FIRE;
            r_out_status <= stt_pkg::ST_OK;
            r_out_owner  <= r_pend_owner;
            r_out_event  <= r_pend_event;
            r_out_last   <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_last <= 1'b1;
            if (r_pend_v) begin
                r_out_kind   <= stt_pkg::KIND_FIRE;
                r_out_status <= stt_pkg::ST_OK;
                r_out_owner  <= r_pend_owner;
                r_out_event  <= r_pend_event;
            end else begin
                r_out_kind   <= stt_pkg::KIND_STATUS;
                r_out_status <= i_cmd.status;
                r_out_owner  <= '0;
                r_out_event  <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_event, r_out_owner, r_out_status};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

/* sv/slot_timer_table.sv */
// ============================================================================
// slot_timer_table
// table of one-shot and periodic timer slots with set, unset, tick, cancel
// ============================================================================
//
//  channel  | dir | tdata                                   | tuser | tlast
//  ---------+-----+-----------------------------------------+-------+------
//  s        | in  | now_ms, owner_id, event_id, duration_ms, | mode  | -
//           |     | periodic                                 |       |
//  m        | out | status, fired_owner, fired_event         | kind  | last
//
//  a command is accepted, then walks the slots in order (up to TIMER_SLOTS,
//  one memory read per cycle), then posts the final result; cancel clears
//  every slot at once without a walk
//  a tick stops walking once MAX_FIRES slots have fired
//  a stalled output holds the walk only when a further result must be posted
//  reset clears every valid bit at once; no clearing pass is needed
//
`timescale 1ns / 1ps
`default_nettype none

module slot_timer_table #(
    parameter int TIMER_SLOTS = stt_pkg::TIMER_SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    // [31:0] now_ms, [39:32] owner_id, [55:40] event_id,
    // [87:56] duration_ms, [88] periodic, [95:89] zero
    input  wire logic [stt_pkg::S_DATA_W-1:0] i_s_tdata,
    // [1:0] mode
    input  wire logic [stt_pkg::S_USER_W-1:0] i_s_tuser,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    // [1:0] status, [9:2] fired_owner, [25:10] fired_event, [31:26] zero
    output logic [stt_pkg::M_DATA_W-1:0]      o_m_tdata,
    // [0] kind
    output logic                              o_m_tuser,
    output logic                              o_m_tlast
);

    stt_pkg::t_cmd  cmd;
    stt_pkg::t_stat stat;

    stt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    stt_dp #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

endmodule

`default_nettype wire

/* sv/stt_checker.sv */
// ============================================================================
// stt_checker
// port-level checks of the slot timer table
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stt_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_s_tvalid,
    input wire logic                         o_s_tready,
    input wire logic                         o_m_tvalid,
    input wire logic                         i_m_tready,
    input wire logic [stt_pkg::M_DATA_W-1:0] o_m_tdata,
    input wire logic                         o_m_tuser,
    input wire logic                         o_m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
        && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready right after a transfer");

    // fired events carry status ok
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == stt_pkg::KIND_FIRE)
        |-> o_m_tdata[1:0] == stt_pkg::ST_OK)
        else $error("fired event with nonzero status");

    // status results are last, with zero owner and event
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == stt_pkg::KIND_STATUS)
        |-> o_m_tlast && (o_m_tdata[25:2] == '0))
        else $error("malformed status result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] == stt_pkg::ST_OK)
        || (o_m_tdata[1:0] == stt_pkg::ST_FULL)
        || (o_m_tdata[1:0] == stt_pkg::ST_NOT_FOUND))
        else $error("undefined status code");

endmodule

bind slot_timer_table stt_checker u_stt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

/* tb/sv/tb_slot_timer_table.sv */
// ============================================================================
// tb_slot_timer_table
// self-checking bench: command stream in, status and fire replies out
// ============================================================================
//
// every accepted command is run through a behavioral copy of the timer
// table kept in a scoreboard; the replies it predicts are queued and each
// reply transfer from the block is compared field by field with the oldest
// one. a short directed sequence hits wrap-around expiry, the expiry
// boundary, a full table, a missing unset, duplicate sets and zero periods.
// random command traffic follows, with random gaps on both sides, a long
// output stall and a pause that lets all outstanding replies drain.
//
`timescale 1ns / 1ps

module tb_slot_timer_table;

    localparam int SLOTS        = stt_pkg::TIMER_SLOTS_DEF;
    localparam int RANDOM_CMDS  = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 30;

    typedef struct {
        logic        kind;
        logic [1:0]  status;
        logic [7:0]  owner;
        logic [15:0] evt;
        logic        last;
    } t_reply;

    class timer_scoreboard;
        bit          slot_armed[SLOTS];
        logic [7:0]  slot_owner[SLOTS];
        logic [15:0] slot_evt[SLOTS];
        logic [31:0] slot_due[SLOTS];
        bit          slot_repeat[SLOTS];
        logic [31:0] slot_period[SLOTS];
        t_reply      pending_replies[$];
        int          errors;
        int          cmd_count[4];
        int          fire_count;
        int          full_count;
        int          miss_count;

        function void push_status(stt_pkg::t_status st);
            t_reply r;
            r = '{stt_pkg::KIND_STATUS, st, 8'd0, 16'd0, 1'b1};
            pending_replies.push_back(r);
            if (st == stt_pkg::ST_FULL) full_count++;
            if (st == stt_pkg::ST_NOT_FOUND) miss_count++;
        endfunction

        function void note_command(stt_pkg::t_mode mode, logic [31:0] now,
                                   logic [7:0] owner, logic [15:0] evt,
                                   logic [31:0] dur, logic per);
            bit          done;
            int          fired;
            logic [31:0] age;
            t_reply      r;
            done  = 0;
            fired = 0;
            cmd_count[mode]++;
            case (mode)
                stt_pkg::MODE_SET: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!done && !slot_armed[i]) begin
                            slot_armed[i]  = 1;
                            slot_owner[i]  = owner;
                            slot_evt[i]    = evt;
                            slot_due[i]    = now + dur;
                            slot_repeat[i] = per;
                            slot_period[i] = dur;
                            done = 1;
                        end
                    end
                    push_status(done ? stt_pkg::ST_OK : stt_pkg::ST_FULL);
                end
                stt_pkg::MODE_UNSET: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!done && slot_armed[i] && slot_owner[i] == owner
                                && slot_evt[i] == evt) begin
                            slot_armed[i] = 0;
                            done = 1;
                        end
                    end
                    push_status(done ? stt_pkg::ST_OK : stt_pkg::ST_NOT_FOUND);
                end
                stt_pkg::MODE_CANCEL: begin
                    for (int i = 0; i < SLOTS; i++) slot_armed[i] = 0;
                    push_status(stt_pkg::ST_OK);
                end
                default: begin
                    // wrap-safe: expired when the expiry lies less than 2^31 ms back
                    for (int i = 0; i < SLOTS; i++) begin
                        age = now - slot_due[i];
                        if (fired < stt_pkg::MAX_FIRES && slot_armed[i]
                                && age < 32'h8000_0000) begin
                            r = '{stt_pkg::KIND_FIRE, stt_pkg::ST_OK, slot_owner[i],
                                  slot_evt[i], 1'b0};
                            pending_replies.push_back(r);
                            fired++;
                            if (slot_repeat[i]) slot_due[i] = now + slot_period[i];
                            else slot_armed[i] = 0;
                        end
                    end
                    fire_count += fired;
                    if (fired == 0) push_status(stt_pkg::ST_OK);
                    else pending_replies[pending_replies.size() - 1].last = 1'b1;
                end
            endcase
        endfunction

        function void check_result(logic kind, logic [1:0] status, logic [7:0] owner,
                                   logic [15:0] evt, logic last);
            t_reply e;
            if (pending_replies.size() == 0) begin
                $error("reply transfer with nothing pending: kind %0d status %0d", kind, status);
                errors++;
                return;
            end
            e = pending_replies.pop_front();
            if (e.kind !== kind) begin
                $error("kind mismatch: expected %0d, actual %0d", e.kind, kind);
                errors++;
            end
            if (e.status !== status) begin
                $error("status mismatch: expected %0d, actual %0d", e.status, status);
                errors++;
            end
            if (e.owner !== owner) begin
                $error("fired_owner mismatch: expected %0d, actual %0d", e.owner, owner);
                errors++;
            end
            if (e.evt !== evt) begin
                $error("fired_event mismatch: expected %0d, actual %0d", e.evt, evt);
                errors++;
            end
            if (e.last !== last) begin
                $error("last mismatch: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_s_tvalid;
    logic                         o_s_tready;
    logic [stt_pkg::S_DATA_W-1:0] i_s_tdata;
    logic [stt_pkg::S_USER_W-1:0] i_s_tuser;
    logic                         o_m_tvalid;
    logic                         i_m_tready;
    logic [stt_pkg::M_DATA_W-1:0] o_m_tdata;
    logic                         o_m_tuser;
    logic                         o_m_tlast;

    timer_scoreboard sb;
    bit              hold_request;
    bit              no_idle;

    slot_timer_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_cmd(input stt_pkg::t_mode mode, input logic [31:0] now,
                            input logic [7:0] owner, input logic [15:0] evt,
                            input logic [31:0] dur, input logic per);
        int gap;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, per, dur, evt, owner, now};
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_command(mode, now, owner, evt, dur, per);
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_owner();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 2));
    endfunction

    function automatic logic [15:0] pick_event();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2));
    endfunction

    // reply side readiness
    initial begin
        int len;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                @(negedge i_clk);
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end
            if ($urandom_range(0, 99) < 25) begin
                len = $urandom_range(20, 60);
                @(negedge i_clk);
                i_m_tready <= 1'b1;
                repeat (len - 1) @(negedge i_clk);
            end else begin
                len = idle_len();
                if (len > 0) begin
                    @(negedge i_clk);
                    i_m_tready <= 1'b0;
                    repeat (len - 1) @(negedge i_clk);
                end
                @(negedge i_clk);
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tuser, o_m_tdata[1:0], o_m_tdata[9:2], o_m_tdata[25:10],
                            o_m_tlast);
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [31:0] clock_ms;
        int          r;
        sb           = new;
        hold_request = 0;
        no_idle      = 0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = stt_pkg::MODE_SET;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: tick, missing unset, cancel
        send_cmd(stt_pkg::MODE_TICK, 32'd0, 8'($urandom()), 16'($urandom()), $urandom(),
                 1'b0);
        send_cmd(stt_pkg::MODE_UNSET, $urandom(), 8'hFF, 16'hFFFF, $urandom(), 1'b1);
        send_cmd(stt_pkg::MODE_CANCEL, $urandom(), 8'($urandom()), 16'($urandom()),
                 $urandom(), 1'b1);
        // expiry wraps past zero, zero duration one-shot
        send_cmd(stt_pkg::MODE_SET, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(stt_pkg::MODE_SET, 32'd0, 8'h00, 16'h0000, 32'd0, 1'b0);
        send_cmd(stt_pkg::MODE_TICK, 32'd0, 8'h00, 16'h0000, 32'd0, 1'b0);
        send_cmd(stt_pkg::MODE_CANCEL, 32'd0, 8'h00, 16'h0000, 32'd0, 1'b0);
        // expiry exactly 2^31 ms ahead
        send_cmd(stt_pkg::MODE_SET, 32'd0, 8'd1, 16'd2, 32'h8000_0000, 1'b0);
        send_cmd(stt_pkg::MODE_TICK, 32'h7FFF_FFFF, 8'd0, 16'd0, 32'd0, 1'b0);
        send_cmd(stt_pkg::MODE_TICK, 32'd0, 8'd0, 16'd0, 32'd0, 1'b0);
        send_cmd(stt_pkg::MODE_TICK, 32'h8000_0000, 8'd0, 16'd0, 32'd0, 1'b0);
        // duplicate sets fill the table, then one more
        for (int i = 0; i < SLOTS; i++)
            send_cmd(stt_pkg::MODE_SET, 32'd100, 8'd3, 16'd9, 32'd0, 1'(i));
        send_cmd(stt_pkg::MODE_SET, 32'd100, 8'd7, 16'd7, 32'd5, 1'b0);
        send_cmd(stt_pkg::MODE_TICK, 32'd100, 8'd0, 16'd0, 32'd0, 1'b0);
        send_cmd(stt_pkg::MODE_TICK, 32'd100, 8'd0, 16'd0, 32'd0, 1'b0);
        send_cmd(stt_pkg::MODE_UNSET, 32'd0, 8'd3, 16'd9, 32'd0, 1'b0);
        send_cmd(stt_pkg::MODE_UNSET, 32'd0, 8'd4, 16'd9, 32'd0, 1'b0);
        send_cmd(stt_pkg::MODE_CANCEL, 32'd0, 8'd0, 16'd0, 32'd0, 1'b0);

        clock_ms = $urandom();
        for (int k = 0; k < RANDOM_CMDS; k++) begin
            if (k == 40) hold_request = 1;
            if (k == 110) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                while (sb.outstanding() != 0) @(posedge i_clk);
            end
            no_idle = (k % 60) >= 45;
            if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
            else clock_ms = clock_ms + $urandom_range(0, 40);
            r = $urandom_range(0, 99);
            if (r < 40)
                send_cmd(stt_pkg::MODE_SET, clock_ms, pick_owner(), pick_event(),
                         ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 60),
                         1'($urandom_range(0, 1)));
            else if (r < 60)
                send_cmd(stt_pkg::MODE_UNSET, $urandom(), pick_owner(), pick_event(),
                         $urandom(), 1'($urandom_range(0, 1)));
            else if (r < 96)
                send_cmd(stt_pkg::MODE_TICK, clock_ms, 8'($urandom()), 16'($urandom()),
                         $urandom(), 1'($urandom_range(0, 1)));
            else
                send_cmd(stt_pkg::MODE_CANCEL, $urandom(), 8'($urandom()), 16'($urandom()),
                         $urandom(), 1'($urandom_range(0, 1)));
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("ran %0d commands: %0d set, %0d unset, %0d tick, %0d cancel",
                 sb.cmd_count[stt_pkg::MODE_SET] + sb.cmd_count[stt_pkg::MODE_UNSET]
                 + sb.cmd_count[stt_pkg::MODE_TICK] + sb.cmd_count[stt_pkg::MODE_CANCEL],
                 sb.cmd_count[stt_pkg::MODE_SET], sb.cmd_count[stt_pkg::MODE_UNSET],
                 sb.cmd_count[stt_pkg::MODE_TICK], sb.cmd_count[stt_pkg::MODE_CANCEL]);
        $display("saw %0d timer fires, %0d table-full and %0d not-found replies",
                 sb.fire_count, sb.full_count, sb.miss_count);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
